/* src/gdr_pkg.sv */
// Shared types, constants and trig helpers for the grid DDA ray caster.
// Used by gdr_div, grid_dda_raycaster, tb_gdr_checker and tb; no dependencies.
package gdr_pkg;

    localparam int MAP_BITS   = 4;
    localparam int MAP_DIM    = 1 << MAP_BITS;
    localparam int MAP_CELLS  = MAP_DIM * MAP_DIM;
    localparam int ADDR_W     = 2 * MAP_BITS;
    localparam int CELL_W     = MAP_BITS + 2;      // signed cell coordinate
    localparam int TILE_W     = 3;
    localparam int COLOR_W    = 24;
    localparam int HEIGHT_W   = 11;

    localparam int SCREEN_HEIGHT = 400;
    localparam int MAX_STEPS     = 64;
    localparam int STEP_CNT_W    = $clog2(MAX_STEPS + 1);

    localparam int FIX_SHIFT  = 12;
    localparam int FIX_ONE    = 1 << FIX_SHIFT;
    localparam int FAR_LIMIT  = 16 * FIX_ONE;
    localparam int NO_STEP    = 32 * FIX_ONE;
    localparam int MIN_CORR   = 64;
    localparam int HMAX_RAW   = SCREEN_HEIGHT * 4;
    localparam int HMAX       = (HMAX_RAW > 2047) ? 2047 : HMAX_RAW;
    localparam int SHADE_MIN  = 30;
    localparam int SHADE_FULL = 256;
    localparam int SHADE_MUL  = 200;

    localparam int DIV_W      = 25;                // dividend / quotient
    localparam int DVS_W      = 17;                // divisor
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int SD_W       = 26;                // side distance accumulators
    localparam int MAG_W      = 13;                // |sin| with 12 fraction bits
    localparam int CORR_W     = 17;

    localparam logic [DIV_W-1:0] STEP_NUM   = DIV_W'(FIX_ONE * FIX_ONE);
    localparam logic [DIV_W-1:0] HEIGHT_NUM = DIV_W'(SCREEN_HEIGHT * FIX_ONE);
    localparam logic [COLOR_W-1:0] COLOR_OTHER = 24'hC8C8C8;

    localparam logic [1:0] REG_TILE_ONE   = 2'd0;
    localparam logic [1:0] REG_TILE_TWO   = 2'd1;
    localparam logic [1:0] REG_TILE_THREE = 2'd2;
    localparam logic [1:0] REG_TILE_FOUR  = 2'd3;

    localparam logic REQ_RAY   = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } trig_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [16:0] sine_q(input logic [6:0] i);
        logic [16:0] v;
        case (i)
            7'd0:  v = 17'd0;     7'd1:  v = 17'd1608;  7'd2:  v = 17'd3216;
            7'd3:  v = 17'd4821;  7'd4:  v = 17'd6424;  7'd5:  v = 17'd8022;
            7'd6:  v = 17'd9616;  7'd7:  v = 17'd11204; 7'd8:  v = 17'd12785;
            7'd9:  v = 17'd14359; 7'd10: v = 17'd15924; 7'd11: v = 17'd17479;
            7'd12: v = 17'd19024; 7'd13: v = 17'd20557; 7'd14: v = 17'd22078;
            7'd15: v = 17'd23586; 7'd16: v = 17'd25080; 7'd17: v = 17'd26558;
            7'd18: v = 17'd28020; 7'd19: v = 17'd29466; 7'd20: v = 17'd30893;
            7'd21: v = 17'd32303; 7'd22: v = 17'd33692; 7'd23: v = 17'd35062;
            7'd24: v = 17'd36410; 7'd25: v = 17'd37736; 7'd26: v = 17'd39040;
            7'd27: v = 17'd40320; 7'd28: v = 17'd41576; 7'd29: v = 17'd42806;
            7'd30: v = 17'd44011; 7'd31: v = 17'd45190; 7'd32: v = 17'd46341;
            7'd33: v = 17'd47464; 7'd34: v = 17'd48559; 7'd35: v = 17'd49624;
            7'd36: v = 17'd50660; 7'd37: v = 17'd51665; 7'd38: v = 17'd52639;
            7'd39: v = 17'd53581; 7'd40: v = 17'd54491; 7'd41: v = 17'd55368;
            7'd42: v = 17'd56212; 7'd43: v = 17'd57022; 7'd44: v = 17'd57798;
            7'd45: v = 17'd58538; 7'd46: v = 17'd59244; 7'd47: v = 17'd59914;
            7'd48: v = 17'd60547; 7'd49: v = 17'd61145; 7'd50: v = 17'd61705;
            7'd51: v = 17'd62228; 7'd52: v = 17'd62714; 7'd53: v = 17'd63162;
            7'd54: v = 17'd63572; 7'd55: v = 17'd63944; 7'd56: v = 17'd64277;
            7'd57: v = 17'd64571; 7'd58: v = 17'd64827; 7'd59: v = 17'd65043;
            7'd60: v = 17'd65220; 7'd61: v = 17'd65358; 7'd62: v = 17'd65457;
            7'd63: v = 17'd65516; 7'd64: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // sine as sign + magnitude, 12 fraction bits; negative half rounds away
    function automatic trig_t sin12(input logic [7:0] a);
        logic [6:0]  i;
        logic [16:0] m;
        logic [17:0] s;
        trig_t       r;
        i = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
        m = sine_q(i);
        s = {1'b0, m} + 18'd15;
        if (a[7]) begin
            r.mag = s[16:4];
            r.neg = (m != 17'd0);
        end else begin
            r.mag = m[16:4];
            r.neg = 1'b0;
        end
        return r;
    endfunction

    function automatic trig_t cos12(input logic [7:0] a);
        return sin12(a + 8'd64);
    endfunction

endpackage

/* src/gdr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module gdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* src/gdr_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gdr_pkg for widths and the status struct.
module gdr_div
    import gdr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output div_stat_t        stat
);
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W:0]       rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic [DVS_W+1:0]     trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // quotient bits shift in where dividend bits shift out
            if (trial >= {1'b0, 1'b0, dvs_reg}) begin
                rem_next = (DVS_W+1)'(trial - {2'b00, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

/* src/grid_dda_raycaster.sv */
// Grid DDA ray caster top level: sequencer, map store, shared multiplier.
// Depends on gdr_pkg, gdr_ram and gdr_div.
//
// Input words (s_valid/s_ready) either write one 3-bit tile into the 16x16
// map (s_req_type = 1) or cast one ray (s_req_type = 0). A tile write gives
// no result. A ray gives one result word on the m_
// channel: wall height, shaded color, hit face and hit flag.
// A ray runs through setup (trig, two step divisions and two multiplies), a step
// and then a map read per grid crossing, and the distance correction, the height
// division and shading before m_valid rises; the divider and multiplier are shared.
// One ray is in flight at a time; s_ready is low from acceptance until the
// result word is taken, so a stalled receiver holds the block.
// Color registers are written on cfg_we with cfg_idx/cfg_data; the user writes them only
// while the block is idle, which the block does not enforce. Reset (aresetn low, synchronous)
// restores the default colors and makes every map cell read as empty; no clearing pass is run.
module grid_dda_raycaster
    import gdr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [COLOR_W-1:0]  cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [15:0]         s_pos_x,
    input  logic [15:0]         s_pos_y,
    input  logic [7:0]          s_ray_angle,
    input  logic [7:0]          s_view_angle,
    input  logic [3:0]          s_tile_col,
    input  logic [3:0]          s_tile_row,
    input  logic [2:0]          s_tile_kind,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HEIGHT_W-1:0] m_wall_height,
    output logic [COLOR_W-1:0]  m_wall_color,
    output logic                m_hit_side,
    output logic                m_wall_hit
);
    typedef enum logic [3:0] {
        S_IDLE, S_TRIG, S_DIVX, S_DIVY, S_MULX, S_MULY, S_STEP, S_LOOK,
        S_CORR, S_DIVH, S_SHADE, S_COLOR, S_OUT
    } state_t;

    state_t state_reg;

    logic [COLOR_W-1:0] col1_reg, col2_reg, col3_reg, col4_reg;
    logic [15:0]        px_reg, py_reg;
    logic [7:0]         ra_reg, va_reg;
    logic               negx_reg, negy_reg;
    logic [MAG_W-1:0]   magx_reg, magy_reg, cdiff_reg;
    logic [DIV_W-1:0]   ddx_reg, ddy_reg;
    logic [SD_W-1:0]    sdx_reg, sdy_reg, dist_reg;
    logic [CELL_W-1:0]  cx_reg, cy_reg;
    logic               side_reg;
    logic [STEP_CNT_W-1:0] n_reg;
    logic [CORR_W-1:0]  corr_reg;
    logic [TILE_W-1:0]  tile_reg;
    logic [8:0]         shade_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [MAP_CELLS-1:0] vld_reg;
    logic               vld_rd_reg;

    logic [HEIGHT_W-1:0] out_h_reg;
    logic [COLOR_W-1:0]  out_c_reg;
    logic                out_side_reg, out_hit_reg;

    // divider
    logic             div_start;
    logic [DIV_W-1:0] div_num;
    logic [DVS_W-1:0] div_den;
    logic [DIV_W-1:0] div_q;
    div_stat_t        div_st;

    gdr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_q),
        .stat     (div_st)
    );

    // map store
    logic               s_acc, wr_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [TILE_W-1:0]  rd_data;

    assign s_acc   = s_valid && s_ready;
    assign wr_en   = s_acc && (s_req_type == REQ_WRITE);
    assign wr_addr = {s_tile_row, s_tile_col};

    gdr_ram #(.WIDTH(TILE_W), .DEPTH(MAP_CELLS)) u_map (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_tile_kind),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // trig for the current ray
    trig_t tx, ty, tc;
    assign tx = cos12(ra_reg);
    assign ty = sin12(ra_reg);
    assign tc = cos12(ra_reg - va_reg);

    // one DDA crossing
    logic              go_x;
    logic [SD_W-1:0]   dist_next;
    logic [CELL_W-1:0] cx_next, cy_next;
    logic [MAG_W-1:0]  fxt, fyt;

    assign go_x      = sdx_reg < sdy_reg;
    assign dist_next = go_x ? sdx_reg : sdy_reg;
    assign cx_next   = go_x ? (negx_reg ? cx_reg - 1'b1 : cx_reg + 1'b1) : cx_reg;
    assign cy_next   = go_x ? cy_reg : (negy_reg ? cy_reg - 1'b1 : cy_reg + 1'b1);
    assign rd_addr   = {cy_next[MAP_BITS-1:0], cx_next[MAP_BITS-1:0]};
    assign fxt = negx_reg ? {1'b0, px_reg[FIX_SHIFT-1:0]}
                          : MAG_W'(FIX_ONE) - {1'b0, px_reg[FIX_SHIFT-1:0]};
    assign fyt = negy_reg ? {1'b0, py_reg[FIX_SHIFT-1:0]}
                          : MAG_W'(FIX_ONE) - {1'b0, py_reg[FIX_SHIFT-1:0]};

    logic oob;
    assign oob = cx_reg[CELL_W-1] || cy_reg[CELL_W-1]
              || (cx_reg[CELL_W-2:MAP_BITS] != '0) || (cy_reg[CELL_W-2:MAP_BITS] != '0);

    logic [TILE_W-1:0] tile_now;
    assign tile_now = oob ? TILE_W'(1) : (vld_rd_reg ? rd_data : '0);

    // shared multiplier
    logic [SD_W-1:0]  mul_a;
    logic [MAG_W-1:0] mul_b;
    logic [SD_W+MAG_W-1:0] mul_p;
    always_comb begin
        case (state_reg)
            S_MULX:  begin mul_a = SD_W'(ddx_reg);  mul_b = fxt; end
            S_MULY:  begin mul_a = SD_W'(ddy_reg);  mul_b = fyt; end
            S_CORR:  begin mul_a = dist_reg;        mul_b = cdiff_reg; end
            S_SHADE: begin mul_a = SD_W'(corr_reg); mul_b = MAG_W'(SHADE_MUL); end
            default: begin mul_a = '0;              mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    logic [CORR_W-1:0] corr_raw;
    assign corr_raw = mul_p[FIX_SHIFT+CORR_W-1:FIX_SHIFT];

    logic [8:0]  shade_raw, shade_cl;
    logic [10:0] shade3;
    assign shade_raw = 9'(SHADE_FULL) - {1'b0, mul_p[23:16]};
    assign shade_cl  = (shade_raw < 9'(SHADE_MIN)) ? 9'(SHADE_MIN) : shade_raw;
    assign shade3    = {2'b00, shade_cl} * 11'd3;

    // base color and dimming
    logic [COLOR_W-1:0] base;
    logic [16:0] r_p, g_p, b_p;
    logic [COLOR_W-1:0] dimmed;
    always_comb begin
        case (tile_reg)
            3'd1:    base = col1_reg;
            3'd2:    base = col2_reg;
            3'd3:    base = col3_reg;
            3'd4:    base = col4_reg;
            default: base = COLOR_OTHER;
        endcase
    end
    assign r_p = base[23:16] * shade_reg;
    assign g_p = base[15:8]  * shade_reg;
    assign b_p = base[7:0]   * shade_reg;
    assign dimmed = shade_reg[8] ? base : {r_p[15:8], g_p[15:8], b_p[15:8]};

    always_comb begin
        div_start = 1'b0;
        div_num   = STEP_NUM;
        div_den   = DVS_W'(magx_reg);
        case (state_reg)
            S_TRIG: begin
                div_start = 1'b1;
                div_den   = DVS_W'(tx.mag);
            end
            S_DIVX: begin
                div_start = div_st.done;
                div_den   = DVS_W'(magy_reg);
            end
            S_CORR: begin
                div_start = 1'b1;
                div_num   = HEIGHT_NUM;
                div_den   = (corr_raw < CORR_W'(MIN_CORR)) ? DVS_W'(MIN_CORR) : corr_raw;
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            vld_reg     <= '0;
            col1_reg    <= 24'hA0A0A0;
            col2_reg    <= 24'hB43C3C;
            col3_reg    <= 24'h3C50C8;
            col4_reg    <= 24'h328C3C;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_TILE_ONE:   col1_reg <= cfg_data;
                    REG_TILE_TWO:   col2_reg <= cfg_data;
                    REG_TILE_THREE: col3_reg <= cfg_data;
                    REG_TILE_FOUR:  col4_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_acc && s_req_type == REQ_RAY) begin
                        px_reg    <= s_pos_x;
                        py_reg    <= s_pos_y;
                        ra_reg    <= s_ray_angle;
                        va_reg    <= s_view_angle;
                        state_reg <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    negx_reg  <= tx.neg;
                    negy_reg  <= ty.neg;
                    magx_reg  <= tx.mag;
                    magy_reg  <= ty.mag;
                    cdiff_reg <= (!tc.neg && tc.mag >= MAG_W'(FIX_ONE / 2))
                                 ? tc.mag : MAG_W'(FIX_ONE / 2);
                    cx_reg    <= CELL_W'(px_reg[15:FIX_SHIFT]);
                    cy_reg    <= CELL_W'(py_reg[15:FIX_SHIFT]);
                    n_reg     <= '0;
                    state_reg <= S_DIVX;
                end
                S_DIVX: begin
                    if (div_st.done) begin
                        ddx_reg   <= (magx_reg == '0) ? DIV_W'(NO_STEP) : div_q;
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_st.done) begin
                        ddy_reg   <= (magy_reg == '0) ? DIV_W'(NO_STEP) : div_q;
                        state_reg <= S_MULX;
                    end
                end
                S_MULX: begin
                    sdx_reg   <= mul_p[FIX_SHIFT+SD_W-1:FIX_SHIFT];
                    state_reg <= S_MULY;
                end
                S_MULY: begin
                    sdy_reg   <= mul_p[FIX_SHIFT+SD_W-1:FIX_SHIFT];
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    dist_reg   <= dist_next;
                    side_reg   <= !go_x;
                    cx_reg     <= cx_next;
                    cy_reg     <= cy_next;
                    vld_rd_reg <= vld_reg[rd_addr];
                    n_reg      <= n_reg + 1'b1;
                    if (go_x) begin
                        sdx_reg <= sdx_reg + SD_W'(ddx_reg);
                    end else begin
                        sdy_reg <= sdy_reg + SD_W'(ddy_reg);
                    end
                    if (dist_next > SD_W'(FAR_LIMIT)) begin
                        out_h_reg    <= '0;
                        out_c_reg    <= '0;
                        out_side_reg <= 1'b0;
                        out_hit_reg  <= 1'b0;
                        state_reg    <= S_OUT;
                    end else begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    tile_reg <= tile_now;
                    if (tile_now != '0) begin
                        state_reg <= S_CORR;
                    end else if (n_reg == STEP_CNT_W'(MAX_STEPS)) begin
                        out_h_reg    <= '0;
                        out_c_reg    <= '0;
                        out_side_reg <= 1'b0;
                        out_hit_reg  <= 1'b0;
                        state_reg    <= S_OUT;
                    end else begin
                        state_reg <= S_STEP;
                    end
                end
                S_CORR: begin
                    corr_reg  <= (corr_raw < CORR_W'(MIN_CORR)) ? CORR_W'(MIN_CORR) : corr_raw;
                    state_reg <= S_DIVH;
                end
                S_DIVH: begin
                    if (div_st.done) begin
                        height_reg <= (div_q > DIV_W'(HMAX)) ? HEIGHT_W'(HMAX)
                                                             : div_q[HEIGHT_W-1:0];
                        state_reg  <= S_SHADE;
                    end
                end
                S_SHADE: begin
                    // side 0 faces get 3/4 brightness
                    shade_reg <= side_reg ? shade_cl : shade3[10:2];
                    state_reg <= S_COLOR;
                end
                S_COLOR: begin
                    out_h_reg    <= height_reg;
                    out_c_reg    <= dimmed;
                    out_side_reg <= side_reg;
                    out_hit_reg  <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = (state_reg == S_OUT);
    assign m_wall_height = out_h_reg;
    assign m_wall_color  = out_c_reg;
    assign m_hit_side    = out_side_reg;
    assign m_wall_hit    = out_hit_reg;

`ifndef ASSERT_OFF
    a_ready_vs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result word is pending");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_wall_hit) |-> (m_wall_height == '0 && m_wall_color == '0
                                      && !m_hit_side))
        else $error("miss word carries nonzero fields");

    a_hit_has_height: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_wall_hit) |-> (m_wall_height != '0))
        else $error("hit word with zero height");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STEP) |-> (n_reg < STEP_CNT_W'(MAX_STEPS)))
        else $error("DDA step count overran");
`endif
endmodule

/* tb/sv/tb_gdr_checker.sv */
// Checker for the grid DDA ray caster: watches both channels and the color port,
// predicts each ray result and compares it field by field. Depends on gdr_pkg.
module tb_gdr_checker
    import gdr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [COLOR_W-1:0]  cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_req_type,
    input  logic [15:0]         s_pos_x,
    input  logic [15:0]         s_pos_y,
    input  logic [7:0]          s_ray_angle,
    input  logic [7:0]          s_view_angle,
    input  logic [3:0]          s_tile_col,
    input  logic [3:0]          s_tile_row,
    input  logic [2:0]          s_tile_kind,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [HEIGHT_W-1:0] m_wall_height,
    input  logic [COLOR_W-1:0]  m_wall_color,
    input  logic                m_hit_side,
    input  logic                m_wall_hit,
    output int                  n_errors,
    output int                  n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COLOR_W-1:0]  color;
        logic                side;
        logic                hit;
    } column_t;

    localparam int QSINE [65] = '{
        0, 1608, 3216, 4821, 6424, 8022, 9616, 11204,
        12785, 14359, 15924, 17479, 19024, 20557, 22078, 23586,
        25080, 26558, 28020, 29466, 30893, 32303, 33692, 35062,
        36410, 37736, 39040, 40320, 41576, 42806, 44011, 45190,
        46341, 47464, 48559, 49624, 50660, 51665, 52639, 53581,
        54491, 55368, 56212, 57022, 57798, 58538, 59244, 59914,
        60547, 61145, 61705, 62228, 62714, 63162, 63572, 63944,
        64277, 64571, 64827, 65043, 65220, 65358, 65457, 65516,
        65536};

    logic [2:0]         tiles [MAP_CELLS];
    logic [COLOR_W-1:0] palette [4];
    column_t            expected_columns [$];

    assign n_pending = expected_columns.size();

    function automatic longint fine_sin(input logic [7:0] a);
        longint m;
        m = a[6] ? QSINE[64 - a[5:0]] : QSINE[a[5:0]];
        return a[7] ? -((m + 15) / 16) : m / 16;
    endfunction

    function automatic longint cross_dist(input longint d);
        longint m;
        m = d < 0 ? -d : d;
        return m == 0 ? longint'(NO_STEP) : longint'(FIX_ONE * FIX_ONE) / m;
    endfunction

    function automatic logic [7:0] scale8(input logic [7:0] c, input longint f);
        return 8'((longint'(c) * f) >> 8);
    endfunction

    function automatic column_t trace_column(input logic [15:0] px, input logic [15:0] py,
                                             input logic [7:0] ra, input logic [7:0] va);
        longint dx, dy, ddx, ddy, sdx, sdy, fx, fy, cx, cy, sx, sy;
        longint hit_dist, cd, corr, height, shade;
        logic [2:0]         kind;
        logic [COLOR_W-1:0] base;
        logic               side;
        column_t            r;
        r = '0;
        kind = '0;
        side = 1'b0;
        hit_dist = 0;
        dx = fine_sin(ra + 8'd64);
        dy = fine_sin(ra);
        cx = px >> 12;
        cy = py >> 12;
        fx = px & 12'hFFF;
        fy = py & 12'hFFF;
        ddx = cross_dist(dx);
        ddy = cross_dist(dy);
        sx = dx < 0 ? -1 : 1;
        sy = dy < 0 ? -1 : 1;
        sdx = ((dx < 0 ? fx : FIX_ONE - fx) * ddx) >>> 12;
        sdy = ((dy < 0 ? fy : FIX_ONE - fy) * ddy) >>> 12;
        for (int n = 0; n < MAX_STEPS; n++) begin
            if (sdx < sdy) begin
                hit_dist = sdx; sdx += ddx; cx += sx; side = 1'b0;
            end else begin
                hit_dist = sdy; sdy += ddy; cy += sy; side = 1'b1;
            end
            if (hit_dist > FAR_LIMIT) return r;
            if (cx < 0 || cx >= MAP_DIM || cy < 0 || cy >= MAP_DIM) kind = 3'd1;
            else kind = tiles[cy * MAP_DIM + cx];
            if (kind != 0) break;
        end
        if (kind == 0) return r;
        cd = fine_sin(ra - va + 8'd64);
        if (cd < FIX_ONE / 2) cd = FIX_ONE / 2;
        corr = (hit_dist * cd) >>> 12;
        if (corr < MIN_CORR) corr = MIN_CORR;
        height = longint'(SCREEN_HEIGHT * FIX_ONE) / corr;
        if (height > HMAX) height = HMAX;
        shade = 256 - (corr * 200) / FAR_LIMIT;
        if (shade < SHADE_MIN) shade = SHADE_MIN;
        if (shade > SHADE_FULL) shade = SHADE_FULL;
        if (!side) shade = shade * 3 / 4;
        base = (kind >= 1 && kind <= 4) ? palette[kind - 1] : COLOR_OTHER;
        if (shade >= 256) r.color = base;
        else r.color = {scale8(base[23:16], shade), scale8(base[15:8], shade),
                        scale8(base[7:0], shade)};
        r.height = HEIGHT_W'(height);
        r.side = side;
        r.hit = 1'b1;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    initial n_errors = 0;

    always @(posedge aclk) begin
        column_t want;
        if (!aresetn) begin
            foreach (tiles[i]) tiles[i] = '0;
            palette[0] = 24'hA0A0A0;
            palette[1] = 24'hB43C3C;
            palette[2] = 24'h3C50C8;
            palette[3] = 24'h328C3C;
            expected_columns.delete();
        end else begin
            if (cfg_we) palette[cfg_idx] = cfg_data;
            if (m_valid && m_ready) begin
                if (expected_columns.size() == 0) begin
                    $display("%0t unexpected result word", $realtime);
                    n_errors++;
                end else begin
                    want = expected_columns.pop_front();
                    if (m_wall_height !== want.height)
                        report("wall_height", m_wall_height, want.height);
                    if (m_wall_color !== want.color)
                        report("wall_color", m_wall_color, want.color);
                    if (m_hit_side !== want.side) report("hit_side", m_hit_side, want.side);
                    if (m_wall_hit !== want.hit) report("wall_hit", m_wall_hit, want.hit);
                end
            end
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_WRITE)
                    tiles[{s_tile_row, s_tile_col}] = s_tile_kind;
                else
                    expected_columns.push_back(
                        trace_column(s_pos_x, s_pos_y, s_ray_angle, s_view_angle));
            end
        end
    end
endmodule

/* tb/sv/tb.sv */
// Top of the ray caster testbench: clock, reset, color writes, word stimulus
// and verdict. Depends on gdr_pkg, grid_dda_raycaster and tb_gdr_checker.
module tb
    import gdr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                cfg_we = 0;
    logic [1:0]          cfg_idx = '0;
    logic [COLOR_W-1:0]  cfg_data = '0;
    logic                s_valid = 0;
    logic                s_ready;
    logic                s_req_type = 0;
    logic [15:0]         s_pos_x = '0, s_pos_y = '0;
    logic [7:0]          s_ray_angle = '0, s_view_angle = '0;
    logic [3:0]          s_tile_col = '0, s_tile_row = '0;
    logic [2:0]          s_tile_kind = '0;
    logic                m_valid;
    logic                m_ready = 0;
    logic [HEIGHT_W-1:0] m_wall_height;
    logic [COLOR_W-1:0]  m_wall_color;
    logic                m_hit_side, m_wall_hit;
    int                  n_errors, n_pending;
    int                  burst_left = 0;

    always #10 aclk = ~aclk;

    grid_dda_raycaster i_dut (.*);
    tb_gdr_checker i_chk (.*);

    // receiver stall pattern: long free runs alternate with random stalls
    initial begin
        int mode;
        forever begin
            @(posedge aclk);
            mode = $rtoi($realtime / 200000.0) % 3;
            m_ready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                        : ($urandom_range(0, 3) == 0);
        end
    end

    // valid stays high between words of a burst; it drops only for a gap or a drain
    task automatic send_word(input logic typ, input logic [15:0] px, input logic [15:0] py,
                             input logic [7:0] ra, input logic [7:0] va,
                             input logic [3:0] col, input logic [3:0] row,
                             input logic [2:0] kind);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1;
        s_req_type <= typ;
        s_pos_x <= px;
        s_pos_y <= py;
        s_ray_angle <= ra;
        s_view_angle <= va;
        s_tile_col <= col;
        s_tile_row <= row;
        s_tile_kind <= kind;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic cast(input logic [15:0] px, input logic [15:0] py,
                        input logic [7:0] ra, input logic [7:0] va);
        send_word(REQ_RAY, px, py, ra, va, 4'($urandom), 4'($urandom), 3'($urandom));
    endtask

    task automatic put_tile(input logic [3:0] col, input logic [3:0] row,
                            input logic [2:0] kind);
        send_word(REQ_WRITE, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  col, row, kind);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (n_pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // leaves cfg_we high; the caller drops it after the last write
    task automatic set_color(input logic [1:0] idx, input logic [COLOR_W-1:0] c);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= c;
        @(posedge aclk);
    endtask

    // random ray from inside the map, mostly in the open middle area
    task automatic random_ray();
        if ($urandom_range(0, 9) == 0)
            cast(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        else
            cast(16'($urandom_range(16'h1000, 16'hEFFF)),
                 16'($urandom_range(16'h1000, 16'hEFFF)),
                 8'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty map, border walls, axes, extremes
        cast(16'h8800, 16'h8800, 8'd0, 8'd0);
        cast(16'h8800, 16'h8800, 8'd64, 8'd64);
        cast(16'h8800, 16'h8800, 8'd128, 8'd0);
        cast(16'h8800, 16'h8800, 8'd192, 8'd255);
        cast(16'h0000, 16'h0000, 8'd160, 8'd32);
        cast(16'hFFFF, 16'hFFFF, 8'd32, 8'd160);
        cast(16'h0FFF, 16'h0010, 8'd128, 8'd0);
        cast(16'h8000, 16'h8000, 8'd100, 8'd10);
        put_tile(4'd9, 4'd8, 3'd2);
        put_tile(4'd7, 4'd8, 3'd3);
        put_tile(4'd8, 4'd9, 3'd4);
        put_tile(4'd8, 4'd7, 3'd7);
        put_tile(4'd15, 4'd15, 3'd5);
        put_tile(4'd0, 4'd0, 3'd6);
        cast(16'h8800, 16'h8800, 8'd0, 8'd0);
        cast(16'h8F00, 16'h8800, 8'd0, 8'd0);
        cast(16'h8800, 16'h8800, 8'd128, 8'd128);
        cast(16'h8800, 16'h8800, 8'd64, 8'd0);
        cast(16'h8800, 16'h8800, 8'd192, 8'd192);
        cast(16'hE800, 16'hE800, 8'd32, 8'd32);
        cast(16'h1800, 16'h1800, 8'd160, 8'd150);
        put_tile(4'd15, 4'd15, 3'd0);
        cast(16'h8800, 16'hFFFF, 8'd255, 8'd0);

        drain();
        set_color(REG_TILE_ONE, 24'hFFFFFF);
        set_color(REG_TILE_TWO, 24'h000000);
        set_color(REG_TILE_THREE, 24'h123456);
        set_color(REG_TILE_FOUR, 24'hFEDCBA);
        cfg_we <= 0;

        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 150; k++) begin
                if ($urandom_range(0, 3) == 0)
                    put_tile(4'($urandom), 4'($urandom), 3'($urandom));
                else
                    random_ray();
            end
            // sender holds off until every result is in
            drain();
            set_color(REG_TILE_ONE, 24'($urandom));
            set_color(REG_TILE_TWO, 24'($urandom));
            set_color(REG_TILE_THREE, (ph == 1) ? 24'h000000 : 24'($urandom));
            set_color(REG_TILE_FOUR, (ph == 2) ? 24'hFFFFFF : 24'($urandom));
            cfg_we <= 0;
        end
        drain();
        if (n_errors == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end

    initial begin
        #30ms;
        $display("tb failed");
        $finish;
    end
endmodule

/* files.f */
src/gdr_pkg.sv
src/gdr_ram.sv
src/gdr_div.sv
src/grid_dda_raycaster.sv
tb/sv/tb_gdr_checker.sv
tb/sv/tb.sv
